@@ rtl/depth_pixel_unproject_macros.svh @@
// Assertion macros for the checker file of the depth pixel unprojection block
`ifndef DEPTH_PIXEL_UNPROJECT_MACROS_SVH
`define DEPTH_PIXEL_UNPROJECT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define DPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dpu_pkg.sv @@
// Package with shared constants, register codes and the pipeline sideband type
`timescale 1ns / 1ps
package dpu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DEPTH_W    = 16;
   localparam int RAY_W      = 20;
   localparam int SCALE_W    = 16;
   localparam int ROOT_W     = 20;
   localparam int SUM_W      = 2 * ROOT_W;
   localparam int DEN_W      = ROOT_W + SCALE_W;
   localparam int QUO_W      = 2 * FRAC_BITS + 1;
   localparam int ZMAG_W     = 23;
   localparam int XY_W       = 27;

   localparam logic [DEPTH_W-1:0] LIMIT_RESET = 16'd64000;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

   typedef enum logic [0:0] {
      REG_DEPTH_LIMIT = 1'b0,
      REG_DEPTH_SCALE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [RAY_W-1:0]   u_mag;
      logic               u_neg;
      logic [RAY_W-1:0]   v_mag;
      logic               v_neg;
      logic [DEPTH_W-1:0] depth;
      logic               zero;
      logic               valid;
      logic               fend;
   } side_type;

endpackage

@@ rtl/dpu_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one result bit per stage
`timescale 1ns / 1ps
module dpu_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [dpu_pkg::SUM_W-1:0]     in_sum,
   input  dpu_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [dpu_pkg::ROOT_W-1:0]    out_root,
   output dpu_pkg::side_type             out_side
);

   localparam int NST     = dpu_pkg::ROOT_W;
   localparam int REM_W   = dpu_pkg::SUM_W;
   localparam int TRIAL_W = dpu_pkg::SUM_W + 2;

   logic                valid_ff [NST];
   logic [REM_W-1:0]    rem_ff   [NST];
   logic [NST-1:0]      root_ff  [NST];
   dpu_pkg::side_type   side_ff  [NST];

   logic                valid_in [NST];
   logic [REM_W-1:0]    rem_in   [NST];
   logic [NST-1:0]      root_in  [NST];
   dpu_pkg::side_type   side_in  [NST];

   always_comb begin
      logic [REM_W-1:0]   rem_src;
      logic [NST-1:0]     root_src;
      logic [TRIAL_W-1:0] trial;
      for (int j = 0; j < NST; j++) begin
         if (j == 0) begin
            valid_in[j] = in_valid;
            rem_src     = in_sum;
            root_src    = '0;
            side_in[j]  = in_side;
         end else begin
            valid_in[j] = valid_ff[j-1];
            rem_src     = rem_ff[j-1];
            root_src    = root_ff[j-1];
            side_in[j]  = side_ff[j-1];
         end
         // (2*root + bit) * bit for the bit under trial
         trial = (TRIAL_W'(root_src) << (NST - j)) + (TRIAL_W'(1) << (2 * (NST - 1 - j)));
         if (TRIAL_W'(rem_src) >= trial) begin
            rem_in[j]  = REM_W'(TRIAL_W'(rem_src) - trial);
            root_in[j] = root_src | (NST'(1) << (NST - 1 - j));
         end else begin
            rem_in[j]  = rem_src;
            root_in[j] = root_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NST; j++) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= valid_in[j];
         end
         if (adv) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_root  = root_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

@@ rtl/dpu_div.sv @@
// Pipelined restoring divider: fraction bits of depth / den, one quotient bit per stage
`timescale 1ns / 1ps
module dpu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [dpu_pkg::DEN_W-1:0]     in_den,
   input  dpu_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [dpu_pkg::QUO_W-1:0]     out_quo,
   output dpu_pkg::side_type             out_side
);

   localparam int NST   = dpu_pkg::QUO_W;
   localparam int DEN_W = dpu_pkg::DEN_W;

   logic                valid_ff [NST];
   logic [DEN_W-1:0]    rem_ff   [NST];
   logic [DEN_W-1:0]    den_ff   [NST];
   logic [NST-1:0]      quo_ff   [NST];
   dpu_pkg::side_type   side_ff  [NST];

   logic                valid_in [NST];
   logic [DEN_W-1:0]    rem_in   [NST];
   logic [DEN_W-1:0]    den_in   [NST];
   logic [NST-1:0]      quo_in   [NST];
   dpu_pkg::side_type   side_in  [NST];

   always_comb begin
      logic [DEN_W-1:0] rem_src;
      logic [NST-1:0]   quo_src;
      logic [DEN_W:0]   rem_dbl;
      for (int j = 0; j < NST; j++) begin
         if (j == 0) begin
            valid_in[j] = in_valid;
            // depth is always below den, so the integer part is zero
            rem_src     = DEN_W'(in_side.depth);
            quo_src     = '0;
            den_in[j]   = in_den;
            side_in[j]  = in_side;
         end else begin
            valid_in[j] = valid_ff[j-1];
            rem_src     = rem_ff[j-1];
            quo_src     = quo_ff[j-1];
            den_in[j]   = den_ff[j-1];
            side_in[j]  = side_ff[j-1];
         end
         rem_dbl = {rem_src, 1'b0};
         if (rem_dbl >= {1'b0, den_in[j]}) begin
            rem_in[j] = DEN_W'(rem_dbl - {1'b0, den_in[j]});
            quo_in[j] = {quo_src[NST-2:0], 1'b1};
         end else begin
            rem_in[j] = DEN_W'(rem_dbl);
            quo_in[j] = {quo_src[NST-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NST; j++) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= valid_in[j];
         end
         if (adv) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_in[j];
            quo_ff[j]  <= quo_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_quo   = quo_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

@@ rtl/depth_pixel_unproject.sv @@
// Top level: depth pixel to camera-space point unprojection pipeline
//
// Input channel req_*: one depth pixel with its ray tangents (Q3.16), a ray-valid
// flag and a frame-end marker. A transfer happens when req_valid is high and
// req_stall is low. Result channel rsp_*: one point (x, y in Q10.16, z in Q6.16,
// z never positive) per pixel, in the same order, with point_valid and
// frame_end_out copied from the pixel.
// Throughput: one pixel per cycle while no stalled result holds the pipeline. The
// pipeline is the 20-stage square root and the 33-stage divider, one bit per
// stage, plus seven stages of squaring, scaling, rounding and output.
// The csr_* port writes depth_limit (index 0) and depth_scale (index 1); write
// them only while the pipeline is empty.
// Reset (synchronous, active high) empties the pipeline and loads depth_limit
// 64000 and depth_scale 1000.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; while no result waits, bubbles drain and input is taken.
`timescale 1ns / 1ps
module depth_pixel_unproject (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_depth_raw,
   input  logic signed [19:0]  req_ray_u,
   input  logic signed [19:0]  req_ray_v,
   input  logic                req_ray_valid,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [26:0]  rsp_point_x,
   output logic signed [26:0]  rsp_point_y,
   output logic signed [22:0]  rsp_point_z,
   output logic                rsp_point_valid,
   output logic                rsp_frame_end_out,
   input  logic                csr_write_enable,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data
);

   localparam int RAY_W  = dpu_pkg::RAY_W;
   localparam int SUM_W  = dpu_pkg::SUM_W;
   localparam int ROOT_W = dpu_pkg::ROOT_W;
   localparam int DEN_W  = dpu_pkg::DEN_W;
   localparam int QUO_W  = dpu_pkg::QUO_W;
   localparam int ZMAG_W = dpu_pkg::ZMAG_W;
   localparam int XY_W   = dpu_pkg::XY_W;
   localparam int FB     = dpu_pkg::FRAC_BITS;
   localparam int PROD_W = ZMAG_W + RAY_W;
   localparam int MAG_W  = PROD_W + 1 - FB;

   localparam logic [ZMAG_W-1:0] ZMAG_MAX = ZMAG_W'(1) << (ZMAG_W - 1);

   function automatic logic [XY_W-1:0] sat_xy(input logic [MAG_W-1:0] mag, input logic neg);
      logic [MAG_W-1:0] neg_lim;
      logic [MAG_W-1:0] pos_lim;
      logic [MAG_W-1:0] twos;
      neg_lim = MAG_W'(1) << (XY_W - 1);
      pos_lim = neg_lim - MAG_W'(1);
      twos    = ~mag + MAG_W'(1);
      if (neg) begin
         sat_xy = (mag > neg_lim) ? XY_W'(neg_lim) : twos[XY_W-1:0];
      end else begin
         sat_xy = (mag > pos_lim) ? XY_W'(pos_lim) : mag[XY_W-1:0];
      end
   endfunction

   logic adv;

   // configuration
   logic [15:0] limit_ff, limit_in;
   logic [15:0] scale_ff, scale_in;

   // stage 1: magnitudes and range check
   logic              s1_valid_ff;
   dpu_pkg::side_type s1_side_ff, s1_side_in;
   // stage 2: squares
   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_squ_ff, s2_sqv_ff;
   dpu_pkg::side_type s2_side_ff;
   // stage 3: sum of squares plus one
   logic              s3_valid_ff;
   logic [SUM_W-1:0]  s3_sum_ff, s3_sum_in;
   dpu_pkg::side_type s3_side_ff;
   // square root output
   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   dpu_pkg::side_type rt_side;
   // stage 4: divisor
   logic              s4_valid_ff;
   logic [DEN_W-1:0]  s4_den_ff, s4_den_in;
   dpu_pkg::side_type s4_side_ff;
   // divider output
   logic              dv_valid;
   logic [QUO_W-1:0]  dv_quo;
   dpu_pkg::side_type dv_side;
   // stage 5: rounded, saturated |z|
   logic              s5_valid_ff;
   logic [ZMAG_W-1:0] s5_zmag_ff, s5_zmag_in;
   dpu_pkg::side_type s5_side_ff;
   // stage 6: products
   logic              s6_valid_ff;
   logic [ZMAG_W-1:0] s6_zmag_ff;
   logic [PROD_W-1:0] s6_px_ff, s6_py_ff;
   dpu_pkg::side_type s6_side_ff;
   // output register
   logic              rsp_valid_ff;
   logic [XY_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [XY_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [ZMAG_W-1:0] rsp_z_ff, rsp_z_in;
   logic              rsp_pv_ff, rsp_fe_ff;

   // hold everything while a finished result is stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      limit_in = limit_ff;
      scale_in = scale_ff;
      if (csr_write_enable) begin
         unique case (dpu_pkg::reg_index_type'(csr_index))
            dpu_pkg::REG_DEPTH_LIMIT: limit_in = csr_data;
            dpu_pkg::REG_DEPTH_SCALE: scale_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dpu_pkg::LIMIT_RESET;
         scale_ff <= dpu_pkg::SCALE_RESET;
      end else begin
         limit_ff <= limit_in;
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      s1_side_in.u_neg = req_ray_u[RAY_W-1];
      s1_side_in.v_neg = req_ray_v[RAY_W-1];
      s1_side_in.u_mag = req_ray_u[RAY_W-1] ? RAY_W'(-req_ray_u) : RAY_W'(req_ray_u);
      s1_side_in.v_mag = req_ray_v[RAY_W-1] ? RAY_W'(-req_ray_v) : RAY_W'(req_ray_v);
      s1_side_in.depth = req_depth_raw;
      s1_side_in.zero  = !req_ray_valid || (req_depth_raw > limit_ff);
      s1_side_in.valid = req_ray_valid;
      s1_side_in.fend  = req_frame_end;
   end

   assign s3_sum_in = s2_squ_ff + s2_sqv_ff + (SUM_W'(1) << (2 * FB));
   assign s4_den_in = DEN_W'(rt_root) * DEN_W'((scale_ff == '0) ? 16'd1 : scale_ff);

   always_comb begin
      logic [QUO_W:0] rnd;
      rnd = ({1'b0, dv_quo} + (QUO_W+1)'(1)) >> 1;
      if (dv_side.zero) begin
         s5_zmag_in = '0;
      end else if (rnd > (QUO_W+1)'(ZMAG_MAX)) begin
         s5_zmag_in = ZMAG_MAX;
      end else begin
         s5_zmag_in = rnd[ZMAG_W-1:0];
      end
   end

   always_comb begin
      logic [PROD_W:0] rx;
      logic [PROD_W:0] ry;
      rx       = {1'b0, s6_px_ff} + ((PROD_W+1)'(1) << (FB - 1));
      ry       = {1'b0, s6_py_ff} + ((PROD_W+1)'(1) << (FB - 1));
      rsp_x_in = sat_xy(rx[PROD_W:FB], !s6_side_ff.u_neg);
      rsp_y_in = sat_xy(ry[PROD_W:FB], !s6_side_ff.v_neg);
      rsp_z_in = ~s6_zmag_ff + ZMAG_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= rt_valid;
         s5_valid_ff  <= dv_valid;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s2_squ_ff  <= SUM_W'(s1_side_ff.u_mag) * SUM_W'(s1_side_ff.u_mag);
         s2_sqv_ff  <= SUM_W'(s1_side_ff.v_mag) * SUM_W'(s1_side_ff.v_mag);
         s2_side_ff <= s1_side_ff;
         s3_sum_ff  <= s3_sum_in;
         s3_side_ff <= s2_side_ff;
         s4_den_ff  <= s4_den_in;
         s4_side_ff <= rt_side;
         s5_zmag_ff <= s5_zmag_in;
         s5_side_ff <= dv_side;
         s6_zmag_ff <= s5_zmag_ff;
         s6_px_ff   <= PROD_W'(s5_zmag_ff) * PROD_W'(s5_side_ff.u_mag);
         s6_py_ff   <= PROD_W'(s5_zmag_ff) * PROD_W'(s5_side_ff.v_mag);
         s6_side_ff <= s5_side_ff;
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_z_ff   <= rsp_z_in;
         rsp_pv_ff  <= s6_side_ff.valid;
         rsp_fe_ff  <= s6_side_ff.fend;
      end
   end

   dpu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s3_valid_ff),
      .in_sum    (s3_sum_ff),
      .in_side   (s3_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   dpu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s4_valid_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_x       = rsp_x_ff;
   assign rsp_point_y       = rsp_y_ff;
   assign rsp_point_z       = rsp_z_ff;
   assign rsp_point_valid   = rsp_pv_ff;
   assign rsp_frame_end_out = rsp_fe_ff;

endmodule

@@ rtl/dpu_checker.sv @@
// Port-level checker for the unprojection block, bound to the top level
`timescale 1ns / 1ps
`include "depth_pixel_unproject_macros.svh"
module dpu_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [15:0]         req_depth_raw,
   input logic signed [19:0]  req_ray_u,
   input logic signed [19:0]  req_ray_v,
   input logic                req_ray_valid,
   input logic                req_frame_end,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [26:0]  rsp_point_x,
   input logic signed [26:0]  rsp_point_y,
   input logic signed [22:0]  rsp_point_z,
   input logic                rsp_point_valid,
   input logic                rsp_frame_end_out,
   input logic                csr_write_enable,
   input logic [0:0]          csr_index,
   input logic [15:0]         csr_data
);

   // a stalled result holds
   `DPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z), "stalled result changed")

   // input is taken whenever no result waits
   `DPU_ASSERT_NOW(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "input stalled with empty output")

   // dropped points carry zero coordinates
   `DPU_ASSERT_NOW(a_drop_zero, clock, reset, rsp_valid && !rsp_point_valid, rsp_point_x == 27'sd0 && rsp_point_y == 27'sd0 && rsp_point_z == 23'sd0, "dropped point not zero")

   // z is never positive
   `DPU_ASSERT_NOW(a_z_sign, clock, reset, rsp_valid, rsp_point_z[22] || rsp_point_z == 23'sd0, "positive z")

   // reset empties the pipeline
   `DPU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind depth_pixel_unproject dpu_checker u_checker (.*);
